/* rtl/uncompressed_gif_stream_writer_defines.svh */
// assertion macros shared by the gif stream writer checkers
// no dependencies; pulled in by `include where properties are written
`ifndef UNCOMPRESSED_GIF_STREAM_WRITER_DEFINES_SVH
`define UNCOMPRESSED_GIF_STREAM_WRITER_DEFINES_SVH

// same-cycle implication, switched off while reset is low
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, switched off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ugsw_pkg.sv */
// shared types, constants and byte tables of the gif stream writer
// no dependencies; compiled before every other file of the block
package ugsw_pkg;

    // sizes
    localparam int BLOCK_BYTES_DEF = 126;
    localparam int CFG_IDX_W       = 2;
    localparam int DIM_W           = 16;
    localparam int PIX_CNT_W       = 32;
    localparam int BLK_W           = 7;
    localparam int SEQ_W           = 6;

    // opcodes of an input item
    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_HEADER  = 2'd0;
    localparam t_opcode OP_FRAME   = 2'd1;
    localparam t_opcode OP_PIXEL   = 2'd2;
    localparam t_opcode OP_TRAILER = 2'd3;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_HEIGHT = 2'd1;

    // kinds of byte sequence the emitter walks through
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_HEADER  = 3'd0;
    localparam t_kind KIND_FRAME   = 3'd1;
    localparam t_kind KIND_PIXEL   = 3'd2;
    localparam t_kind KIND_TRAILER = 3'd3;
    localparam t_kind KIND_DROP    = 3'd4;

    // last byte indexes of the sequences, and the frame sequence length
    localparam logic [SEQ_W-1:0] HDR_LAST     = 6'd37;
    localparam logic [SEQ_W-1:0] FRM_LAST     = 6'd18;
    localparam logic [SEQ_W-1:0] FRM_END_LAST = 6'd21;
    localparam logic [SEQ_W-1:0] FRM_LEN      = 6'd19;

    // stream byte codes
    localparam logic [7:0] CLEAR_CODE = 8'h80;
    localparam logic [7:0] EOI_CODE   = 8'h81;
    localparam logic [7:0] EXT_INTRO  = 8'h21;
    localparam logic [7:0] GCE_LABEL  = 8'hF9;
    localparam logic [7:0] IMG_SEP    = 8'h2C;
    localparam logic [7:0] CODE_SIZE  = 8'h07;
    localparam logic [7:0] TRAILER    = 8'h3B;

    // one accepted item as the emitter sees it
    typedef struct packed {
        t_kind            kind;
        logic [SEQ_W-1:0] last_idx;
        logic             blk_open;
        logic [7:0]       blk_len;
        logic [7:0]       code;
    } t_plan;

    // end-of-information sequence 01 81 00
    function automatic logic [7:0] end_byte(input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = 8'h01;
            2'd1:    b = EOI_CODE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // file header with logical screen descriptor, colour table and loop extension
    function automatic logic [7:0] header_byte(input logic [SEQ_W-1:0] idx,
                                               input logic [DIM_W-1:0] w,
                                               input logic [DIM_W-1:0] h);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'h47;
            6'd1:    b = 8'h49;
            6'd2:    b = 8'h46;
            6'd3:    b = 8'h38;
            6'd4:    b = 8'h39;
            6'd5:    b = 8'h61;
            6'd6:    b = w[7:0];
            6'd7:    b = w[15:8];
            6'd8:    b = h[7:0];
            6'd9:    b = h[15:8];
            6'd10:   b = 8'h80;
            6'd13:   b = 8'hFF;
            6'd14:   b = 8'hFF;
            6'd15:   b = 8'hFF;
            6'd19:   b = EXT_INTRO;
            6'd20:   b = 8'hFF;
            6'd21:   b = 8'h0B;
            6'd22:   b = 8'h4E;
            6'd23:   b = 8'h45;
            6'd24:   b = 8'h54;
            6'd25:   b = 8'h53;
            6'd26:   b = 8'h43;
            6'd27:   b = 8'h41;
            6'd28:   b = 8'h50;
            6'd29:   b = 8'h45;
            6'd30:   b = 8'h32;
            6'd31:   b = 8'h2E;
            6'd32:   b = 8'h30;
            6'd33:   b = 8'h03;
            6'd34:   b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // graphic control extension, image descriptor, code size, optional end sequence
    function automatic logic [7:0] frame_byte(input logic [SEQ_W-1:0] idx,
                                              input logic [DIM_W-1:0] w,
                                              input logic [DIM_W-1:0] h);
        logic [SEQ_W-1:0] k;
        logic [7:0]       b;
        k = idx - FRM_LEN;
        case (idx)
            6'd0:    b = EXT_INTRO;
            6'd1:    b = GCE_LABEL;
            6'd2:    b = 8'h04;
            6'd3:    b = 8'h08;
            6'd4:    b = 8'h04;
            6'd8:    b = IMG_SEP;
            6'd13:   b = w[7:0];
            6'd14:   b = w[15:8];
            6'd15:   b = h[7:0];
            6'd16:   b = h[15:8];
            6'd18:   b = CODE_SIZE;
            6'd19:   b = end_byte(k[1:0]);
            6'd20:   b = end_byte(k[1:0]);
            6'd21:   b = end_byte(k[1:0]);
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/ugsw_ifs.sv */
// valid/ready channel interfaces of the gif stream writer
// depends on ugsw_pkg for field types

// input item channel
interface ugsw_item_if;
    import ugsw_pkg::*;
    logic       valid;
    logic       ready;
    t_opcode    opcode;
    logic [7:0] pixel_code;
    modport source (output valid, output opcode, output pixel_code, input ready);
    modport sink   (input valid, input opcode, input pixel_code, output ready);
endinterface

// result byte channel
interface ugsw_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       status;
    modport source (output valid, output out_byte, output last_of_run, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input status,
                    output ready);
endinterface

// register write channel
interface ugsw_cfg_if;
    import ugsw_pkg::*;
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [DIM_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/ugsw_frame_ctl.sv */
// frame tracking: pixel count, sub-block count and frame-open flag
// turns each accepted item into an emit plan; depends on ugsw_pkg
module ugsw_frame_ctl #(
    parameter int BLOCK_BYTES = ugsw_pkg::BLOCK_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  ugsw_pkg::t_opcode             i_opcode,
    input  logic [7:0]                    i_pixel_code,
    input  logic [ugsw_pkg::DIM_W-1:0]    i_frame_width,
    input  logic [ugsw_pkg::DIM_W-1:0]    i_frame_height,
    output ugsw_pkg::t_plan               o_plan
);
    import ugsw_pkg::*;

    logic [PIX_CNT_W-1:0] r_pixels_left, n_pixels_left;
    logic [BLK_W-1:0]     r_block_left, n_block_left;
    logic                 r_frame_open, n_frame_open;

    logic [PIX_CNT_W-1:0] w_area;
    logic                 w_zero;
    logic                 w_blk_open;
    logic [BLK_W-1:0]     w_size;
    logic [BLK_W-1:0]     w_blk_cur;
    logic                 w_end;

    // frame size and sub-block bookkeeping
    assign w_area     = {{(PIX_CNT_W-DIM_W){1'b0}}, i_frame_width}
                      * {{(PIX_CNT_W-DIM_W){1'b0}}, i_frame_height};
    assign w_zero     = (i_frame_width == '0) || (i_frame_height == '0);
    assign w_blk_open = (r_block_left == '0);
    assign w_size     = (r_pixels_left < PIX_CNT_W'(BLOCK_BYTES))
                      ? r_pixels_left[BLK_W-1:0] : BLK_W'(BLOCK_BYTES);
    assign w_blk_cur  = w_blk_open ? w_size : r_block_left;
    assign w_end      = (r_pixels_left == PIX_CNT_W'(1));

    // plan and next state for the item on the input
    always_comb begin
        n_pixels_left   = r_pixels_left;
        n_block_left    = r_block_left;
        n_frame_open    = r_frame_open;
        o_plan.kind     = KIND_TRAILER;
        o_plan.last_idx = '0;
        o_plan.blk_open = 1'b0;
        o_plan.blk_len  = 8'(w_size) + 8'd1;
        o_plan.code     = i_pixel_code;
        case (i_opcode)
            OP_HEADER: begin
                o_plan.kind     = KIND_HEADER;
                o_plan.last_idx = HDR_LAST;
            end
            OP_FRAME: begin
                o_plan.kind     = KIND_FRAME;
                o_plan.last_idx = w_zero ? FRM_END_LAST : FRM_LAST;
                n_pixels_left   = w_area;
                n_block_left    = '0;
                n_frame_open    = !w_zero;
            end
            OP_PIXEL: begin
                if (!r_frame_open) begin
                    o_plan.kind = KIND_DROP;
                end else begin
                    o_plan.kind     = KIND_PIXEL;
                    o_plan.blk_open = w_blk_open;
                    o_plan.last_idx = (w_blk_open ? SEQ_W'(2) : SEQ_W'(0))
                                    + (w_end ? SEQ_W'(3) : SEQ_W'(0));
                    n_pixels_left   = r_pixels_left - PIX_CNT_W'(1);
                    n_block_left    = w_end ? '0 : w_blk_cur - BLK_W'(1);
                    n_frame_open    = !w_end;
                end
            end
            default: begin
                o_plan.kind = KIND_TRAILER;
            end
        endcase
    end

    // state update on each input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_left <= '0;
            r_block_left  <= '0;
            r_frame_open  <= 1'b0;
        end else if (i_take) begin
            r_pixels_left <= n_pixels_left;
            r_block_left  <= n_block_left;
            r_frame_open  <= n_frame_open;
        end
    end

endmodule

/* rtl/uncompressed_gif_stream_writer.sv */
// top level of the uncompressed two-colour gif89a stream writer
// depends on ugsw_pkg, ugsw_ifs and ugsw_frame_ctl
//
// Usage
//   i_cfg    : register writes, index 0 frame width, 1 frame height; always ready.
//              Write only while no transaction is in flight.
//   i_item   : opcode 0 file header, 1 frame start, 2 pixel, 3 trailer.
//   o_result : one stream byte per transaction; last_of_run marks the final byte
//              an item produced, status flags a pixel dropped with no frame open.
// Timing
//   An item is taken into the emit register, and each of its bytes then passes
//   through the output register onto o_result. The single output byte register
//   sets the rate while the receiver holds ready high: one byte per cycle. An
//   item produces 1 byte for a pixel inside a sub-block, 3 at a sub-block
//   start, up to 6 at frame end, 19 or 22 for a frame start, 38 for a header.
//   The next item is taken in the cycle the current one hands over its last byte,
//   so a pixel run in a sub-block flows at one pixel per cycle when not stalled.
// Reset and stalls
//   Synchronous active-low reset clears the config and busy registers, the
//   frame state and the output valid. When the receiver holds ready low the
//   output byte holds and i_item.ready drops when the emit register stalls.
module uncompressed_gif_stream_writer #(
    parameter int BLOCK_BYTES = ugsw_pkg::BLOCK_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ugsw_item_if.sink            i_item,
    ugsw_cfg_if.sink             i_cfg,
    ugsw_result_if.source        o_result
);
    import ugsw_pkg::*;

    logic [DIM_W-1:0] r_frame_width;
    logic [DIM_W-1:0] r_frame_height;

    logic             r_busy;
    t_plan            r_plan;
    logic [SEQ_W-1:0] r_idx;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_status;

    t_plan            w_plan;
    logic             w_take;
    logic             w_load;
    logic             w_step;
    logic             w_seq_last;
    logic [SEQ_W-1:0] w_pix_base;
    logic [SEQ_W-1:0] w_pix_end;
    logic [7:0]       w_byte;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= '0;
            r_frame_height <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_WIDTH:  r_frame_width  <= i_cfg.data;
                REG_HEIGHT: r_frame_height <= i_cfg.data;
                default:    r_frame_width  <= r_frame_width;
            endcase
        end
    end

    // frame tracking and plan for the incoming item
    ugsw_frame_ctl #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_frame_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (w_take),
        .i_opcode       (i_item.opcode),
        .i_pixel_code   (i_item.pixel_code),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_plan         (w_plan)
    );

    // handshake between emit register and output register
    assign w_load       = !r_out_valid || o_result.ready;
    assign w_step       = r_busy && w_load;
    assign w_seq_last   = (r_idx == r_plan.last_idx);
    assign i_item.ready = !r_busy || (w_step && w_seq_last);
    assign w_take       = i_item.valid && i_item.ready;

    // emit register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_busy <= 1'b1;
        end else if (w_step && w_seq_last) begin
            r_busy <= 1'b0;
        end
    end

    // emit register payload and byte index
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_plan <= w_plan;
            r_idx  <= '0;
        end else if (w_step) begin
            r_idx  <= r_idx + SEQ_W'(1);
        end
    end

    // byte selection for the current index
    assign w_pix_base = r_plan.blk_open ? SEQ_W'(2) : SEQ_W'(0);
    assign w_pix_end  = r_idx - w_pix_base - SEQ_W'(1);

    always_comb begin
        case (r_plan.kind)
            KIND_HEADER: w_byte = header_byte(r_idx, r_frame_width, r_frame_height);
            KIND_FRAME:  w_byte = frame_byte(r_idx, r_frame_width, r_frame_height);
            KIND_PIXEL: begin
                if (r_idx < w_pix_base) begin
                    w_byte = r_idx[0] ? CLEAR_CODE : r_plan.blk_len;
                end else if (r_idx == w_pix_base) begin
                    w_byte = r_plan.code;
                end else begin
                    w_byte = end_byte(w_pix_end[1:0]);
                end
            end
            KIND_TRAILER: w_byte = TRAILER;
            default:      w_byte = 8'h00;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_byte   <= w_byte;
            r_out_last   <= w_seq_last;
            r_out_status <= (r_plan.kind == KIND_DROP);
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.out_byte    = r_out_byte;
    assign o_result.last_of_run = r_out_last;
    assign o_result.status      = r_out_status;

endmodule

/* rtl/ugsw_checker.sv */
// port-level checks on the result channel of the gif stream writer
// depends on uncompressed_gif_stream_writer_defines.svh; bound to the top level
`include "uncompressed_gif_stream_writer_defines.svh"

module ugsw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic       i_last,
    input logic       i_status
);

    // reset empties the output register
    `ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_valid, "output valid after reset")

    // a dropped pixel is a single zero byte closing its run
    `ASSERT_IMPLY(a_drop_shape, i_clk, i_rst_n, i_valid && i_status, i_last && (i_out_byte == 8'h00), "bad drop byte")

    // a run never breaks off: after a non-final transaction the next byte is ready at once
    `ASSERT_NEXT(a_run_gapless, i_clk, i_rst_n, i_valid && i_ready && !i_last, i_valid, "gap inside a run")

    // stalled byte holds
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_out_byte) && $stable(i_last) && $stable(i_status), "output changed under stall")

endmodule

bind uncompressed_gif_stream_writer ugsw_checker u_ugsw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_result.valid),
    .i_ready    (o_result.ready),
    .i_out_byte (o_result.out_byte),
    .i_last     (o_result.last_of_run),
    .i_status   (o_result.status)
);
